### hw/rtl/frwl_pkg.sv
// Shared types and constants of the fair FIFO reader/writer lock.
package frwl_pkg;

  localparam int QUEUE_DEPTH       = 16;
  localparam int REQUESTER_COUNT   = 16;
  localparam int READER_COUNT_BITS = 8;

  localparam int REQ_W   = 4;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [READER_COUNT_BITS-1:0] READER_LIMIT = '1;

  // command codes
  localparam logic [1:0] CMD_SHARED    = 2'd0;
  localparam logic [1:0] CMD_EXCLUSIVE = 2'd1;
  localparam logic [1:0] CMD_RELEASE   = 2'd2;
  localparam logic [1:0] CMD_CANCEL    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_BLOCK     = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;
  localparam logic [2:0] ST_NOTWAIT   = 3'd6;

  typedef struct packed {
    logic             excl;
    logic [REQ_W-1:0] req;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### hw/rtl/frwl_cell.sv
// One wait-queue cell: holds an entry, takes its neighbor's on a shift or a new entry on a load.
module frwl_cell import frwl_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nbr,
  input  entry_t     din,
  output entry_t     q
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= nbr;
    end else if (ctrl.load) begin
      q <= din;
    end
  end

endmodule

### hw/rtl/fifo_reader_writer_lock_core.sv
// Top level of the fair FIFO reader/writer lock with direct hand-off.
//
// Each input beat carries a shared request, an exclusive request, a release
// or a cancel from a numbered requester. The block answers with an
// acknowledgement beat, then one grant beat per waiter handed the lock
// (a run of shared heads, or one exclusive head); tlast marks the final
// beat of each input. The wait queue is a row of QUEUE_DEPTH cells that
// shift toward the head; there is no clearing pass after reset. A request
// or release goes from IDLE to ACK, a cancel first walks the queue in SCAN
// for the requester, and any grants follow in GRANT; the ACK and GRANT
// beats wait while the output register is full and not taken. The next beat
// is accepted once the last result of the previous one is in the output
// register, even while that result waits to be taken.
module fifo_reader_writer_lock_core import frwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] requester, [4] no_wait, [7:5] zero
  input  logic [1:0] s_tuser,   // [1:0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] grantee, [4] granted_exclusive, [7:5] zero
  output logic [2:0] m_tuser,   // [2:0] status
  output logic       m_tlast
);

  typedef enum logic [1:0] {IDLE, SCAN, ACK, GRANT} state_t;

  state_t                       state, state_next;
  logic [1:0]                   cmd;
  logic [REQ_W-1:0]             who;
  logic                         nowait;
  logic                         found, found_next;
  logic [IDX_W-1:0]             fidx, fidx_next;
  logic [COUNT_W-1:0]           sidx, sidx_next;
  logic [COUNT_W-1:0]           count, count_next;
  logic [READER_COUNT_BITS-1:0] readers, readers_next;
  logic                         writer, writer_next;

  logic             out_who;
  logic [REQ_W-1:0] out_req;
  logic [2:0]       out_status;
  logic             out_excl;
  logic             out_last;

  logic             emit;
  logic [REQ_W-1:0] o_who;
  logic [2:0]       o_status;
  logic             o_excl;
  logic             o_last;
  logic             out_free;
  logic             oor;
  logic             gnext;
  entry_t           head_after;

  logic             do_push;
  logic             do_shift;
  logic [IDX_W-1:0] shift_from;
  entry_t           push_entry;

  entry_t     q    [QUEUE_DEPTH];
  entry_t     nbr  [QUEUE_DEPTH];
  cell_ctrl_t ctrl [QUEUE_DEPTH];

  function automatic logic compat(input logic excl, input logic w,
                                  input logic [READER_COUNT_BITS-1:0] r);
    logic ok;
    if (w) begin
      ok = 1'b0;
    end else if (excl) begin
      ok = (r == '0);
    end else begin
      ok = (r != READER_LIMIT);
    end
    return ok;
  endfunction

  // Row of queue cells; cell 0 is the head, each but the last shifts in from the next.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr[i] = q[i];
    end else begin : g_mid
      assign nbr[i] = q[i+1];
    end
    assign ctrl[i].shift = do_shift && (IDX_W'(i) >= shift_from);
    assign ctrl[i].load  = do_push && (COUNT_W'(i) == count);

    frwl_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl[i]),
      .nbr  (nbr[i]),
      .din  (push_entry),
      .q    (q[i])
    );
  end

  assign s_tready   = (state == IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign oor        = (int'(who) >= REQUESTER_COUNT);
  assign push_entry = '{excl: cmd[0], req: who};
  assign head_after = (fidx == '0) ? q[1] : q[0];

  always_comb begin
    state_next   = state;
    sidx_next    = sidx;
    found_next   = found;
    fidx_next    = fidx;
    count_next   = count;
    readers_next = readers;
    writer_next  = writer;
    emit         = 1'b0;
    o_who        = who;
    o_status     = ST_NOTWAIT;
    o_excl       = 1'b0;
    o_last       = 1'b1;
    do_push      = 1'b0;
    do_shift     = 1'b0;
    shift_from   = '0;
    gnext        = 1'b0;

    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          sidx_next  = '0;
          state_next = (s_tuser == CMD_CANCEL) ? SCAN : ACK;
        end
      end

      // Walk the queue one cell a cycle for the oldest entry of this requester.
      SCAN: begin
        if (sidx >= count) begin
          found_next = 1'b0;
          state_next = ACK;
        end else if (q[sidx[IDX_W-1:0]].req == who) begin
          found_next = 1'b1;
          fidx_next  = sidx[IDX_W-1:0];
          state_next = ACK;
        end else begin
          sidx_next = sidx + COUNT_W'(1);
        end
      end

      // Apply the command and send its acknowledgement beat.
      ACK: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = IDLE;
          if (oor) begin
            o_status = ST_NOTWAIT;
          end else if (cmd == CMD_SHARED || cmd == CMD_EXCLUSIVE) begin
            o_excl = cmd[0];
            if (count == '0 && compat(cmd[0], writer, readers)) begin
              o_status = ST_GRANTED;
              if (cmd[0]) begin
                writer_next = 1'b1;
              end else begin
                readers_next = readers + READER_COUNT_BITS'(1);
              end
            end else if (nowait) begin
              o_status = ST_BLOCK;
            end else if (count == COUNT_W'(QUEUE_DEPTH)) begin
              o_status = ST_FULL;
            end else begin
              o_status   = ST_QUEUED;
              do_push    = 1'b1;
              count_next = count + COUNT_W'(1);
            end
          end else if (cmd == CMD_RELEASE) begin
            o_status = ST_RELEASED;
            if (writer) begin
              writer_next = 1'b0;
              o_excl      = 1'b1;
            end else if (readers != '0) begin
              readers_next = readers - READER_COUNT_BITS'(1);
            end
            gnext      = (count != '0) && compat(q[0].excl, writer_next, readers_next);
            o_last     = !gnext;
            state_next = gnext ? GRANT : IDLE;
          end else if (!found) begin
            o_status = ST_NOTWAIT;
          end else begin
            o_status   = ST_CANCELLED;
            o_excl     = q[fidx].excl;
            do_shift   = 1'b1;
            shift_from = fidx;
            count_next = count - COUNT_W'(1);
            gnext      = (count > COUNT_W'(1)) && compat(head_after.excl, writer, readers);
            o_last     = !gnext;
            state_next = gnext ? GRANT : IDLE;
          end
        end
      end

      // Hand the lock to the head, one grant beat a cycle while the output register is free.
      GRANT: begin
        if (out_free) begin
          emit       = 1'b1;
          o_who      = q[0].req;
          o_status   = ST_GRANTED;
          o_excl     = q[0].excl;
          do_shift   = 1'b1;
          count_next = count - COUNT_W'(1);
          if (q[0].excl) begin
            writer_next = 1'b1;
          end else begin
            readers_next = readers + READER_COUNT_BITS'(1);
          end
          // Stop after an exclusive grant, an empty queue, an exclusive next
          // head, or when the reader count reaches its limit.
          o_last     = q[0].excl || (count == COUNT_W'(1)) || q[1].excl ||
                       (readers == READER_LIMIT - READER_COUNT_BITS'(1));
          state_next = o_last ? IDLE : GRANT;
        end
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      readers  <= '0;
      writer   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      readers <= readers_next;
      writer  <= writer_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: command capture, scan pointer and output beat.
  always_ff @(posedge clk) begin
    if (state == IDLE && s_tvalid) begin
      cmd    <= s_tuser;
      who    <= s_tdata[REQ_W-1:0];
      nowait <= s_tdata[4];
    end
    sidx  <= sidx_next;
    found <= found_next;
    fidx  <= fidx_next;
    if (emit) begin
      out_req    <= o_who;
      out_status <= o_status;
      out_excl   <= o_excl;
      out_last   <= o_last;
    end
  end

  assign out_who = 1'b0;
  assign m_tdata = {3'b000, out_excl | out_who, out_req};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // An accepted beat closes the input side in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command is still being processed");

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // Exclusive and shared holders never coexist.
  a_mode_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(writer && readers != '0))
    else $error("writer held while readers are active");

  // Grant beats are only sent while something is queued.
  a_grant_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == GRANT) |-> (count != '0))
    else $error("grant run on an empty queue");

endmodule
